// ----- src/pexst_pkg.sv -----
// ----------------------------------------------------------------------------
// pexst_pkg
// Shared types and constants for the pin expander slave transfer block.
// ----------------------------------------------------------------------------
package pexst_pkg;

   localparam int unsigned OP_W        = 3;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned WORD_W      = 16;
   localparam int unsigned CSR_INDEX_W = 1;

   // transfer operation codes, codes 6 and 7 do nothing
   typedef enum logic [OP_W-1:0] {
      OP_LOW_CHANGE  = 3'd0,
      OP_HIGH_CHANGE = 3'd1,
      OP_READ_MATCH  = 3'd2,
      OP_TX_REQUEST  = 3'd3,
      OP_WRITE_MATCH = 3'd4,
      OP_RX_BYTE     = 3'd5
   } op_type;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_HIGH_INPUT_MASK = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_OUTPUT_PIN_MASK = 1'd1;

   localparam logic [BYTE_W-1:0] MASK_RESET = 8'hFF;

   // bytes per state word, kept as the last value of the sent count
   localparam logic [1:0] SENT_LAST = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [BYTE_W-1:0] pin_levels;
      logic [BYTE_W-1:0] rx_byte;
   } req_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0] tx_byte;
      logic              tx_valid;
      logic [BYTE_W-1:0] port_value;
      logic              port_write;
      logic [WORD_W-1:0] state_word;
      logic              request_line;
   } rsp_item_type;

   typedef struct packed {
      logic                   valid;
      logic [CSR_INDEX_W-1:0] index;
      logic [BYTE_W-1:0]      data;
   } cfg_write_type;

endpackage

// ----- src/pexst_if.sv -----
// ----------------------------------------------------------------------------
// pexst_if
// Request, response and register-write channels of the pin expander block.
// ----------------------------------------------------------------------------
interface pexst_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] op;
   logic [7:0] pin_levels;
   logic [7:0] rx_byte;

   modport source (output valid, output op, output pin_levels, output rx_byte,
                   input ready);
   modport sink (input valid, input op, input pin_levels, input rx_byte,
                 output ready);
endinterface

interface pexst_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  tx_byte;
   logic        tx_valid;
   logic [7:0]  port_value;
   logic        port_write;
   logic [15:0] state_word;
   logic        request_line;

   modport source (output valid, output tx_byte, output tx_valid, output port_value,
                   output port_write, output state_word, output request_line,
                   input ready);
   modport sink (input valid, input tx_byte, input tx_valid, input port_value,
                 input port_write, input state_word, input request_line,
                 output ready);
endinterface

interface pexst_csr_if;
   logic       valid;
   logic       ready;
   logic [0:0] index;
   logic [7:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/pexst_core.sv -----
// ----------------------------------------------------------------------------
// pexst_core
// Transfer state: input word, request flag, send shifter and receive count.
// One request is applied per step, the response is formed combinationally.
// ----------------------------------------------------------------------------
module pexst_core
   import pexst_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  req_item_type  item,
   input  cfg_write_type cfg,
   output rsp_item_type  result
);

   logic [BYTE_W-1:0] high_mask_ff, high_mask_in;
   logic [BYTE_W-1:0] out_mask_ff, out_mask_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic              pending_ff, pending_in;
   logic [WORD_W-1:0] shift_ff, shift_in;
   logic [WORD_W-1:0] snap_ff, snap_in;
   logic [1:0]        sent_cnt_ff, sent_cnt_in;
   logic [BYTE_W-1:0] recv_cnt_ff, recv_cnt_in;
   logic [BYTE_W-1:0] pins_n;

   assign pins_n = ~item.pin_levels;

   always_comb begin
      high_mask_in = high_mask_ff;
      out_mask_in  = out_mask_ff;
      if (cfg.valid) begin
         case (cfg.index)
            REG_HIGH_INPUT_MASK: high_mask_in = cfg.data;
            REG_OUTPUT_PIN_MASK: out_mask_in  = cfg.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      word_in     = word_ff;
      pending_in  = pending_ff;
      shift_in    = shift_ff;
      snap_in     = snap_ff;
      sent_cnt_in = sent_cnt_ff;
      recv_cnt_in = recv_cnt_ff;
      result      = '0;
      case (op_type'(item.op))
         OP_LOW_CHANGE: begin
            word_in    = {word_ff[WORD_W-1:BYTE_W], pins_n};
            pending_in = 1'b1;
         end
         OP_HIGH_CHANGE: begin
            word_in    = {pins_n & high_mask_ff, word_ff[BYTE_W-1:0]};
            pending_in = 1'b1;
         end
         OP_READ_MATCH: begin
            shift_in    = word_ff;
            snap_in     = word_ff;
            sent_cnt_in = 2'd0;
         end
         OP_TX_REQUEST: begin
            if (sent_cnt_ff != SENT_LAST) begin
               result.tx_byte  = shift_ff[BYTE_W-1:0];
               result.tx_valid = 1'b1;
               shift_in        = {{BYTE_W{1'b0}}, shift_ff[WORD_W-1:BYTE_W]};
               sent_cnt_in     = sent_cnt_ff + 2'd1;
               // drop the request only if nothing changed since the snapshot
               if (sent_cnt_in == SENT_LAST && snap_ff == word_ff) begin
                  pending_in = 1'b0;
               end
            end
         end
         OP_WRITE_MATCH: begin
            recv_cnt_in = '0;
         end
         OP_RX_BYTE: begin
            recv_cnt_in = recv_cnt_ff + 8'd1;
            if (recv_cnt_in == 8'd1) begin
               result.port_value = item.rx_byte & out_mask_ff;
               result.port_write = 1'b1;
            end
         end
         default: ;
      endcase
      result.state_word   = word_in;
      result.request_line = pending_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_mask_ff <= MASK_RESET;
         out_mask_ff  <= MASK_RESET;
         word_ff      <= '0;
         pending_ff   <= 1'b0;
         shift_ff     <= '0;
         snap_ff      <= '0;
         sent_cnt_ff  <= '0;
         recv_cnt_ff  <= '0;
      end else begin
         high_mask_ff <= high_mask_in;
         out_mask_ff  <= out_mask_in;
         if (step) begin
            word_ff     <= word_in;
            pending_ff  <= pending_in;
            shift_ff    <= shift_in;
            snap_ff     <= snap_in;
            sent_cnt_ff <= sent_cnt_in;
            recv_cnt_ff <= recv_cnt_in;
         end
      end
   end

`ifndef SYNTHESIS
   a_sent_cnt_range: assert property (@(posedge clock) disable iff (reset)
      sent_cnt_ff != 2'd3)
      else $error("sent count out of range");

   a_tx_done_holds: assert property (@(posedge clock) disable iff (reset)
      step && item.op == OP_TX_REQUEST && sent_cnt_ff == SENT_LAST
      |=> $stable(shift_ff) && $stable(pending_ff))
      else $error("transmit after last byte changed state");

   a_change_raises: assert property (@(posedge clock) disable iff (reset)
      step && (item.op == OP_LOW_CHANGE || item.op == OP_HIGH_CHANGE) |=> pending_ff)
      else $error("pin change did not raise request line");

   a_port_first_byte: assert property (@(posedge clock) disable iff (reset)
      step && result.port_write |=> recv_cnt_ff == 8'd1)
      else $error("port written on other than first byte");
`endif

endmodule

// ----- src/pin_expander_slave_transfer_top.sv -----
// ----------------------------------------------------------------------------
// pin_expander_slave_transfer_top
// Input expander slave transfer logic with request and response registers.
//
//   channel   direction  contents
//   req_ch    in         op, pin_levels, rx_byte
//   rsp_ch    out        tx_byte, tx_valid, port_value, port_write,
//                        state_word, request_line
//   csr_ch    in         index, data (register write, always ready)
//
// One request per clock cycle sustained while responses are taken; a response is
// valid once its request has passed the input register, then the response register.
// The state update in pexst_core is one combinational pass between those registers.
// Synchronous active-high reset clears state, masks return to all ones.
// A stalled response holds in its register; the input register takes one more
// request, then the request side stalls until the response is taken.
// ----------------------------------------------------------------------------
module pin_expander_slave_transfer_top
   import pexst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   pexst_req_if.sink   req_ch,
   pexst_rsp_if.source rsp_ch,
   pexst_csr_if.sink   csr_ch
);

   logic          in_valid_ff, in_valid_in;
   req_item_type  in_item_ff, in_item_in;
   logic          out_valid_ff, out_valid_in;
   rsp_item_type  out_item_ff, out_item_in;
   logic          advance;
   logic          req_fire;
   rsp_item_type  core_result;
   cfg_write_type cfg;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready   = !in_valid_ff || advance;
   assign req_fire       = req_ch.valid && req_ch.ready;
   assign csr_ch.ready   = 1'b1;

   assign cfg.valid = csr_ch.valid;
   assign cfg.index = csr_ch.index;
   assign cfg.data  = csr_ch.data;

   pexst_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (core_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_item_in  = '{op: req_ch.op, pin_levels: req_ch.pin_levels,
                         rx_byte: req_ch.rx_byte};
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_item_in  = core_result;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.tx_byte      = out_item_ff.tx_byte;
   assign rsp_ch.tx_valid     = out_item_ff.tx_valid;
   assign rsp_ch.port_value   = out_item_ff.port_value;
   assign rsp_ch.port_write   = out_item_ff.port_write;
   assign rsp_ch.state_word   = out_item_ff.state_word;
   assign rsp_ch.request_line = out_item_ff.request_line;

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pin expander slave transfer block. Directed
// requests cover each operation and its corner cases, then random transfer
// sequences run under several mask settings and sender and receiver stall
// patterns. A cycle-free shadow of the block predicts every response.
// ----------------------------------------------------------------------------
module tb_top;
   import pexst_pkg::*;

   localparam int unsigned RANDOM_REQUESTS = 1560;
   localparam int unsigned MAX_REPORTS     = 40;

   // codes the block must ignore
   localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #4 clock = ~clock;

   pexst_req_if req_ch ();
   pexst_rsp_if rsp_ch ();
   pexst_csr_if csr_ch ();

   pin_expander_slave_transfer_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // shadow copy of the expander state
   logic [WORD_W-1:0] shadow_word     = '0;
   logic              shadow_pending  = 1'b0;
   logic [WORD_W-1:0] shadow_shift    = '0;
   logic [WORD_W-1:0] shadow_snapshot = '0;
   logic [1:0]        shadow_sent     = '0;
   logic [BYTE_W-1:0] shadow_recv     = '0;
   logic [BYTE_W-1:0] shadow_high_mask = MASK_RESET;
   logic [BYTE_W-1:0] shadow_out_mask  = MASK_RESET;

   rsp_item_type expected_transfers[$];
   rsp_item_type oldest_transfer;
   int unsigned  mismatch_count = 0;
   int unsigned  requests_sent  = 0;
   int unsigned  send_idle_pct  = 0;
   int unsigned  rsp_stall_pct  = 0;

   function automatic rsp_item_type expander_step(input logic [OP_W-1:0] op,
                                                  input logic [BYTE_W-1:0] pins,
                                                  input logic [BYTE_W-1:0] rx);
      rsp_item_type r;
      r = '0;
      case (op)
         OP_LOW_CHANGE: begin
            shadow_word[7:0] = ~pins;
            shadow_pending   = 1'b1;
         end
         OP_HIGH_CHANGE: begin
            shadow_word[15:8] = ~pins & shadow_high_mask;
            shadow_pending    = 1'b1;
         end
         OP_READ_MATCH: begin
            shadow_shift    = shadow_word;
            shadow_snapshot = shadow_word;
            shadow_sent     = '0;
         end
         OP_TX_REQUEST: begin
            if (shadow_sent < SENT_LAST) begin
               r.tx_byte    = shadow_shift[7:0];
               r.tx_valid   = 1'b1;
               shadow_shift = shadow_shift >> 8;
               shadow_sent  = shadow_sent + 2'd1;
               // line only clears if nothing moved while the word went out
               if (shadow_sent == SENT_LAST && shadow_snapshot == shadow_word)
                  shadow_pending = 1'b0;
            end
         end
         OP_WRITE_MATCH: begin
            shadow_recv = '0;
         end
         OP_RX_BYTE: begin
            shadow_recv = shadow_recv + 8'd1;
            if (shadow_recv == 8'd1) begin
               r.port_value = rx & shadow_out_mask;
               r.port_write = 1'b1;
            end
         end
         default: ;
      endcase
      r.state_word   = shadow_word;
      r.request_line = shadow_pending;
      return r;
   endfunction

   function automatic logic [BYTE_W-1:0] rand_byte();
      return BYTE_W'($urandom_range(255));
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatch_count < MAX_REPORTS)
         $display("%0t: mismatch: %s", $realtime, what);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [WORD_W-1:0] got,
                              input logic [WORD_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
   endtask

   // response checker and receiver stalls
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_transfers.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            oldest_transfer = expected_transfers.pop_front();
            check_field("tx_byte", WORD_W'(rsp_ch.tx_byte),
                        WORD_W'(oldest_transfer.tx_byte));
            check_field("tx_valid", WORD_W'(rsp_ch.tx_valid),
                        WORD_W'(oldest_transfer.tx_valid));
            check_field("port_value", WORD_W'(rsp_ch.port_value),
                        WORD_W'(oldest_transfer.port_value));
            check_field("port_write", WORD_W'(rsp_ch.port_write),
                        WORD_W'(oldest_transfer.port_write));
            check_field("state_word", rsp_ch.state_word, oldest_transfer.state_word);
            check_field("request_line", WORD_W'(rsp_ch.request_line),
                        WORD_W'(oldest_transfer.request_line));
         end
      end
      rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   task automatic send_request(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] pins,
                               input logic [BYTE_W-1:0] rx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.op         <= op;
      req_ch.pin_levels <= pins;
      req_ch.rx_byte    <= rx;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_transfers.push_back(expander_step(op, pins, rx));
      requests_sent++;
   endtask

   task automatic drain_responses();
      req_ch.valid <= 1'b0;
      while (expected_transfers.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [BYTE_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      if (idx == REG_HIGH_INPUT_MASK)
         shadow_high_mask = value;
      else
         shadow_out_mask = value;
   endtask

   // only called with the block idle
   task automatic set_masks(input logic [BYTE_W-1:0] high_mask,
                            input logic [BYTE_W-1:0] out_mask);
      drain_responses();
      write_register(REG_HIGH_INPUT_MASK, high_mask);
      write_register(REG_OUTPUT_PIN_MASK, out_mask);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic test_reset_defaults();
      // transmit with no read match yet sends the cleared shift word
      send_request(OP_TX_REQUEST, 8'hFF, 8'hFF);
      send_request(OP_TX_REQUEST, 8'h00, 8'h00);
      send_request(OP_TX_REQUEST, 8'hFF, 8'h00);
      send_request(OP_SPARE_A, 8'hFF, 8'hFF);
      send_request(OP_SPARE_B, 8'h00, 8'h00);
   endtask

   task automatic test_pin_changes();
      send_request(OP_LOW_CHANGE, 8'hFF, 8'h00);
      send_request(OP_LOW_CHANGE, 8'h00, 8'hFF);
      send_request(OP_HIGH_CHANGE, 8'hFF, 8'h00);
      send_request(OP_HIGH_CHANGE, 8'h00, 8'hFF);
      send_request(OP_LOW_CHANGE, 8'h5A, 8'h00);
      send_request(OP_HIGH_CHANGE, 8'hA5, 8'h00);
   endtask

   task automatic test_read_transfer();
      send_request(OP_READ_MATCH, 8'h00, 8'hFF);
      send_request(OP_TX_REQUEST, 8'h00, 8'h00);
      send_request(OP_TX_REQUEST, 8'h00, 8'h00);
      send_request(OP_TX_REQUEST, 8'h00, 8'h00);
      // word changes mid-transfer so the line stays up
      send_request(OP_READ_MATCH, 8'hFF, 8'h00);
      send_request(OP_LOW_CHANGE, 8'h0F, 8'h00);
      send_request(OP_TX_REQUEST, 8'hFF, 8'hFF);
      send_request(OP_TX_REQUEST, 8'hFF, 8'hFF);
   endtask

   task automatic test_write_transfer();
      // first byte after reset counts as first byte of a write
      send_request(OP_RX_BYTE, 8'h00, 8'h33);
      send_request(OP_WRITE_MATCH, 8'hFF, 8'hFF);
      send_request(OP_RX_BYTE, 8'hFF, 8'hFF);
      send_request(OP_RX_BYTE, 8'h00, 8'h00);
      send_request(OP_WRITE_MATCH, 8'h00, 8'h00);
      send_request(OP_RX_BYTE, 8'h00, 8'h00);
   endtask

   task automatic test_masks();
      set_masks(8'h0F, 8'hF0);
      send_request(OP_HIGH_CHANGE, 8'h00, 8'h00);
      send_request(OP_WRITE_MATCH, 8'h00, 8'h00);
      send_request(OP_RX_BYTE, 8'h00, 8'hFF);
      set_masks(8'h00, 8'h00);
      send_request(OP_HIGH_CHANGE, 8'h00, 8'h00);
      send_request(OP_WRITE_MATCH, 8'h00, 8'h00);
      send_request(OP_RX_BYTE, 8'h00, 8'hFF);
      set_masks(MASK_RESET, MASK_RESET);
   endtask

   task automatic test_recv_wrap();
      // the receive count wraps, so byte 257 of a write drives the port again
      send_request(OP_WRITE_MATCH, rand_byte(), rand_byte());
      repeat (257) send_request(OP_RX_BYTE, rand_byte(), rand_byte());
   endtask

   task automatic random_sequence();
      int unsigned pick;
      int unsigned n;
      pick = $urandom_range(99);
      if (pick < 30) begin
         n = $urandom_range(3, 1);
         repeat (n)
            send_request($urandom_range(1) ? OP_HIGH_CHANGE : OP_LOW_CHANGE,
                         rand_byte(), rand_byte());
      end else if (pick < 60) begin
         send_request(OP_READ_MATCH, rand_byte(), rand_byte());
         if ($urandom_range(3) == 0)
            send_request(OP_LOW_CHANGE, rand_byte(), rand_byte());
         send_request(OP_TX_REQUEST, rand_byte(), rand_byte());
         if ($urandom_range(4) == 0)
            send_request(OP_HIGH_CHANGE, rand_byte(), rand_byte());
         send_request(OP_TX_REQUEST, rand_byte(), rand_byte());
         if ($urandom_range(4) == 0)
            send_request(OP_TX_REQUEST, rand_byte(), rand_byte());
      end else if (pick < 80) begin
         send_request(OP_WRITE_MATCH, rand_byte(), rand_byte());
         n = $urandom_range(4, 1);
         repeat (n) send_request(OP_RX_BYTE, rand_byte(), rand_byte());
      end else begin
         send_request(OP_W'($urandom_range(7)), rand_byte(), rand_byte());
      end
   endtask

   task automatic test_random_phases();
      int unsigned phase;
      int unsigned target;
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               set_masks(8'h00, MASK_RESET);
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               set_masks(MASK_RESET, 8'h00);
               send_idle_pct = 81;
               rsp_stall_pct = 0;
            end
            2: begin
               set_masks(rand_byte(), rand_byte());
               send_idle_pct = 0;
               rsp_stall_pct = 81;
            end
            default: begin
               set_masks(MASK_RESET, MASK_RESET);
               send_idle_pct = 38;
               rsp_stall_pct = 38;
            end
         endcase
         target = requests_sent + RANDOM_REQUESTS / 4;
         while (requests_sent < target) random_sequence();
      end
   endtask

   initial begin
      req_ch.valid      <= 1'b0;
      req_ch.op         <= OP_LOW_CHANGE;
      req_ch.pin_levels <= '0;
      req_ch.rx_byte    <= '0;
      csr_ch.valid      <= 1'b0;
      csr_ch.index      <= REG_HIGH_INPUT_MASK;
      csr_ch.data       <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_pin_changes();
      test_read_transfer();
      test_write_transfer();
      test_masks();
      test_recv_wrap();
      test_random_phases();
      drain_responses();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ----- files.f -----
src/pexst_pkg.sv
src/pexst_if.sv
src/pexst_core.sv
src/pin_expander_slave_transfer_top.sv
verif/tb_top.sv
